// File: design/lrfb_pkg.sv
// ----------------------------------------------------------------------------
// lrfb_pkg
// Shared types, codes and brightness tables for the LED ring frame builder.
// ----------------------------------------------------------------------------
package lrfb_pkg;

    // Default geometry
    localparam int LED_COUNT_C  = 12;
    localparam int QUAD_COUNT_C = 4;

    // Widest ring the slot masks are sized for
    localparam int LED_MAX_C  = 32;
    localparam int SLOT_W_C   = $clog2(LED_MAX_C);
    localparam int CNT_W_C    = SLOT_W_C + 1;

    // Percent saturation and scaling divisors
    localparam int PCT_MAX_C   = 100;
    localparam int FULL_DIV_C  = 100;
    localparam int HALF_DIV_C  = 200;
    localparam int ALL_SEL_C   = 255;

    // Header words
    localparam logic [15:0] HDR_SYNC_C     = 16'hFC00;
    localparam logic [15:0] HDR_IND_CMD_C  = 16'hFC02;
    localparam logic [15:0] HDR_IND_CFG_C  = 16'h9002;
    localparam logic [15:0] HDR_LEG_CMD_C  = 16'hFC00;
    localparam logic [15:0] HDR_LEG_CFG_C  = 16'h0000;

    // Operation codes
    localparam logic [1:0] OP_RING     = 2'd0;
    localparam logic [1:0] OP_HEAD     = 2'd1;
    localparam logic [1:0] OP_FILL     = 2'd2;
    localparam logic [1:0] OP_FILL_END = 2'd3;

    // Request word
    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] red_percent;
        logic [6:0] green_percent;
        logic [6:0] blue_percent;
        logic [7:0] led_select;
    } t_req;

    // Result word
    typedef struct packed {
        logic [15:0] frame_word;
        logic        last_word;
    } t_rsp;

    // Classified job handed from front to back
    typedef struct packed {
        logic                 legacy;
        logic [CNT_W_C-1:0]   slot_cnt;
        logic [LED_MAX_C-1:0] full_mask;
        logic [LED_MAX_C-1:0] half_mask;
        logic [6:0]           red;
        logic [6:0]           green;
        logic [6:0]           blue;
    } t_job;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Frame sequencer states
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_HDR0,
        SEQ_HDR1,
        SEQ_HDR2,
        SEQ_BLUE,
        SEQ_RED,
        SEQ_GREEN
    } t_seq_state;

    // Brightness lookup, indexed by saturated percent
    typedef logic [15:0] t_lvl_tbl [0:PCT_MAX_C];

    function automatic t_lvl_tbl build_full_tbl();
        t_lvl_tbl tbl;
        for (int i = 0; i <= PCT_MAX_C; i++) begin
            tbl[i] = 16'((i * 65535) / FULL_DIV_C);
        end
        return tbl;
    endfunction

    function automatic t_lvl_tbl build_half_tbl();
        t_lvl_tbl tbl;
        for (int i = 0; i <= PCT_MAX_C; i++) begin
            tbl[i] = 16'((i * 65535) / HALF_DIV_C);
        end
        return tbl;
    endfunction

    localparam t_lvl_tbl FULL_TBL = build_full_tbl();
    localparam t_lvl_tbl HALF_TBL = build_half_tbl();

endpackage

// File: design/lrfb_queue.sv
// ----------------------------------------------------------------------------
// lrfb_queue
// Two-entry job queue between the request classifier and the frame sequencer.
// ----------------------------------------------------------------------------
module lrfb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lrfb_pkg::t_job  i_job,
    input  logic            i_pop,
    output lrfb_pkg::t_job  o_job,
    output lrfb_pkg::t_q_stat o_stat
);
    import lrfb_pkg::*;

    t_job       r_mem [0:1];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       do_push, do_pop;

    // Status and guarded strobes
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    // Pointer and count update
    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: design/lrfb_front.sv
// ----------------------------------------------------------------------------
// lrfb_front
// Accepts requests, saturates percents and works out which slots are lit at
// full and at half brightness. Holds the LED mode register.
// ----------------------------------------------------------------------------
module lrfb_front #(
    parameter int LED_COUNT  = lrfb_pkg::LED_COUNT_C,
    parameter int QUAD_COUNT = lrfb_pkg::QUAD_COUNT_C
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lrfb_pkg::t_req    i_in_word,
    // queue side
    input  lrfb_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output lrfb_pkg::t_job    o_job
);
    import lrfb_pkg::*;

    logic       r_led_mode;
    logic [7:0] sel;
    logic [7:0] n_led8, n_ring8;
    logic       is_ring, legacy;
    logic       ring_ok, head_ok;
    logic [7:0] before8, after8, cnt8, start8;
    logic [LED_MAX_C-1:0] full_mask, half_mask;

    // Mode register, reset to individual LEDs
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_led_mode <= i_cfg_data;
        end
    end

    // Handshake: take a word whenever the queue has room
    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    // Frame geometry
    assign sel     = i_in_word.led_select;
    assign is_ring = (i_in_word.operation == OP_RING);
    assign legacy  = is_ring && !r_led_mode;
    assign n_led8  = 8'(LED_COUNT);
    assign n_ring8 = legacy ? 8'(QUAD_COUNT) : n_led8;

    assign ring_ok = (sel != 8'd0) && (sel <= n_ring8);
    assign head_ok = (sel != 8'd0) && (sel <= n_led8);

    // Head neighbours with wrap
    assign before8 = (sel == 8'd1)   ? n_led8 - 8'd1 : sel - 8'd2;
    assign after8  = (sel == n_led8) ? 8'd0          : sel;

    // Fill bounds
    assign cnt8   = (sel > n_led8) ? n_led8 : sel;
    assign start8 = (sel == 8'd0)  ? 8'd1   : sel;

    // Per-slot lit decisions
    always_comb begin
        full_mask = '0;
        half_mask = '0;
        for (int i = 0; i < LED_MAX_C; i++) begin
            unique case (i_in_word.operation)
                OP_RING: begin
                    full_mask[i] = (8'(i) < n_ring8) &&
                                   ((ring_ok && (sel == 8'(i + 1))) ||
                                    (sel == 8'(ALL_SEL_C)));
                end
                OP_HEAD: begin
                    full_mask[i] = head_ok && (sel == 8'(i + 1));
                    half_mask[i] = head_ok && ((before8 == 8'(i)) || (after8 == 8'(i)));
                end
                OP_FILL: begin
                    full_mask[i] = (8'(i) < n_led8) && (8'(i) + cnt8 >= n_led8);
                end
                OP_FILL_END: begin
                    full_mask[i] = (8'(i) < n_led8) &&
                                   ({1'b0, 8'(i)} + {1'b0, start8} <= {1'b0, n_led8});
                end
                default: begin
                    full_mask[i] = 1'b0;
                end
            endcase
        end
    end

    // Job word for the sequencer
    always_comb begin
        o_job.legacy    = legacy;
        o_job.slot_cnt  = CNT_W_C'(n_ring8);
        o_job.full_mask = full_mask;
        o_job.half_mask = half_mask;
        o_job.red   = (i_in_word.red_percent > 7'(PCT_MAX_C)) ?
                      7'(PCT_MAX_C) : i_in_word.red_percent;
        o_job.green = (i_in_word.green_percent > 7'(PCT_MAX_C)) ?
                      7'(PCT_MAX_C) : i_in_word.green_percent;
        o_job.blue  = (i_in_word.blue_percent > 7'(PCT_MAX_C)) ?
                      7'(PCT_MAX_C) : i_in_word.blue_percent;
    end

endmodule

// File: design/lrfb_back.sv
// ----------------------------------------------------------------------------
// lrfb_back
// Frame sequencer: walks header and blue/red/green slot words of one job and
// drives them through a registered output stage.
// ----------------------------------------------------------------------------
module lrfb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // queue side
    input  lrfb_pkg::t_q_stat i_q_stat,
    input  lrfb_pkg::t_job    i_job,
    output logic              o_pop,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lrfb_pkg::t_rsp    o_out_word
);
    import lrfb_pkg::*;

    t_seq_state            r_state, n_state;
    t_job                  r_job;
    logic [SLOT_W_C-1:0]   r_slot;
    logic                  r_out_valid;
    t_rsp                  r_out_word;

    logic        emit, advance, step, last;
    logic [6:0]  pct;
    logic [15:0] level, word;

    // Output stage can take a word
    assign advance = !r_out_valid || !i_out_stall;
    assign emit    = (r_state != SEQ_IDLE);
    assign step    = emit && advance;
    assign last    = (r_state == SEQ_GREEN) &&
                     ({1'b0, r_slot} == r_job.slot_cnt - CNT_W_C'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE:  n_state = i_q_stat.empty ? SEQ_IDLE : SEQ_HDR0;
            SEQ_HDR0:  if (step) n_state = SEQ_HDR1;
            SEQ_HDR1:  if (step) n_state = SEQ_HDR2;
            SEQ_HDR2:  if (step) n_state = SEQ_BLUE;
            SEQ_BLUE:  if (step) n_state = SEQ_RED;
            SEQ_RED:   if (step) n_state = SEQ_GREEN;
            SEQ_GREEN: begin
                if (step) begin
                    if (!last) begin
                        n_state = SEQ_BLUE;
                    end else begin
                        n_state = i_q_stat.empty ? SEQ_IDLE : SEQ_HDR0;
                    end
                end
            end
            default:   n_state = SEQ_IDLE;
        endcase
    end

    // Word selection and queue pop
    always_comb begin
        pct  = 7'd0;
        word = 16'h0000;
        unique case (r_state)
            SEQ_BLUE:  pct = r_job.blue;
            SEQ_RED:   pct = r_job.red;
            SEQ_GREEN: pct = r_job.green;
            default:   pct = 7'd0;
        endcase
        priority if (r_job.half_mask[r_slot]) begin
            level = HALF_TBL[pct];
        end else if (r_job.full_mask[r_slot]) begin
            level = FULL_TBL[pct];
        end else begin
            level = 16'h0000;
        end
        unique case (r_state)
            SEQ_HDR0: word = HDR_SYNC_C;
            SEQ_HDR1: word = r_job.legacy ? HDR_LEG_CMD_C : HDR_IND_CMD_C;
            SEQ_HDR2: word = r_job.legacy ? HDR_LEG_CFG_C : HDR_IND_CFG_C;
            SEQ_BLUE, SEQ_RED, SEQ_GREEN: word = level;
            default:  word = 16'h0000;
        endcase
        o_pop = !i_q_stat.empty &&
                ((r_state == SEQ_IDLE) || (step && last));
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_slot <= '0;
        end else if (step && (r_state == SEQ_GREEN)) begin
            r_slot <= r_slot + SLOT_W_C'(1);
        end
        if (step) begin
            r_out_word.frame_word <= word;
            r_out_word.last_word  <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: design/led_ring_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// led_ring_frame_builder_unit
// Builds one LED driver frame per request: 3 header words, then blue, red,
// green per slot. Front classifies, a two-entry queue decouples, back emits.
// ----------------------------------------------------------------------------
// Path: request -> queue entry -> sequencer job register -> output register.
// Throughput: one word per cycle while i_out_stall is low, 3 + 3*LED_COUNT
//   words per frame (39 by default), 3 + 3*QUAD_COUNT for a legacy ring
//   frame; frames follow each other without a gap while the queue holds a
//   job, set by the one-word-per-cycle sequencer in the back end.
// Reset: synchronous, active low; clears queue, sequencer and output valid,
//   and sets the LED mode to individual LEDs.
module led_ring_frame_builder_unit #(
    parameter int LED_COUNT  = lrfb_pkg::LED_COUNT_C,
    parameter int QUAD_COUNT = lrfb_pkg::QUAD_COUNT_C
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lrfb_pkg::t_req i_in_word,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output lrfb_pkg::t_rsp o_out_word
);
    import lrfb_pkg::*;

    t_q_stat q_stat;
    t_job    push_job, pop_job;
    logic    push, pop;

    // Request classifier
    lrfb_front #(
        .LED_COUNT  (LED_COUNT),
        .QUAD_COUNT (QUAD_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_job       (push_job)
    );

    // Job queue
    lrfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_stat  (q_stat)
    );

    // Frame sequencer
    lrfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// File: design/lrfb_checker.sv
// ----------------------------------------------------------------------------
// lrfb_checker
// Port-level checks on the frame builder: reset, output hold, frame framing.
// ----------------------------------------------------------------------------
module lrfb_checker #(
    parameter int LED_COUNT  = lrfb_pkg::LED_COUNT_C,
    parameter int QUAD_COUNT = lrfb_pkg::QUAD_COUNT_C
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_cfg_valid,
    input logic           o_cfg_ready,
    input logic           i_cfg_data,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input lrfb_pkg::t_req i_in_word,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input lrfb_pkg::t_rsp o_out_word
);
    import lrfb_pkg::*;

    localparam int IND_LEN = 3 + 3 * LED_COUNT;
    localparam int LEG_LEN = 3 + 3 * QUAD_COUNT;
    localparam int MAX_LEN = (IND_LEN > LEG_LEN) ? IND_LEN : LEG_LEN;
    localparam int POS_W   = $clog2(3 + 3 * LED_MAX_C);

    logic [POS_W-1:0] r_pos;
    logic             out_take;

    assign out_take = o_out_valid && !i_out_stall;

    // Word position inside the current output frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (out_take) begin
            r_pos <= o_out_word.last_word ? '0 : r_pos + POS_W'(1);
        end
    end

    // Output stage empties under reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // Every frame opens with the sync word
    a_frame_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && (r_pos == '0) |-> o_out_word.frame_word == HDR_SYNC_C)
        else $error("frame does not start with sync word");

    // Last word only at a legal frame length
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && o_out_word.last_word |->
            (r_pos == POS_W'(IND_LEN - 1)) || (r_pos == POS_W'(LEG_LEN - 1)))
        else $error("frame length mismatch");

    // Words beyond the longest frame never appear
    a_frame_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && (r_pos == POS_W'(MAX_LEN - 1)) |-> o_out_word.last_word)
        else $error("frame runs past its end");

endmodule

bind led_ring_frame_builder_unit lrfb_checker #(
    .LED_COUNT  (LED_COUNT),
    .QUAD_COUNT (QUAD_COUNT)
) u_lrfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
